// ===== rtl/cdq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque core.
// ----------------------------------------------------------------------------
package cdq_pkg;

  // Command carried in the input tuser
  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_QUERY      = 3'd4
  } cdq_cmd_e;

  // Status carried in the output tuser
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } cdq_status_e;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned OUT_DATA_W = 80;

  // Value reported for front and back when the deque is empty
  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = '1;

  // One result beat, front value in the lowest bits
  typedef struct packed {
    logic                      is_full;
    logic                      is_empty;
    logic [COUNT_W-1:0]        count;
    logic signed [DATA_W-1:0]  back_value;
    logic signed [DATA_W-1:0]  front_value;
  } cdq_result_t;

endpackage : cdq_pkg
`default_nettype wire

// ===== rtl/cdq_ring_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_ring_ram
// Ring store: one write port, two registered read ports, write-first on a
// read of the address being written in the same cycle.
// ----------------------------------------------------------------------------
module cdq_ring_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7,
  parameter int unsigned DW    = 32
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_a_i,
  input  wire logic [AW-1:0] raddr_b_i,
  output logic      [DW-1:0] rdata_a_o,
  output logic      [DW-1:0] rdata_b_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_a_q;
  logic [DW-1:0] rdata_b_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read ports, new data forwarded on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_a_i)) begin
      rdata_a_q <= wdata_i;
    end else begin
      rdata_a_q <= mem[raddr_a_i];
    end
    if (we_i && (waddr_i == raddr_b_i)) begin
      rdata_b_q <= wdata_i;
    end else begin
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule : cdq_ring_ram
`default_nettype wire

// ===== rtl/cdq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_ctrl
// Head/tail indices, element count and cached end values. Decodes one
// command per cycle while accept_i is high and gives the post-operation result.
// ----------------------------------------------------------------------------
module cdq_ctrl #(
  parameter int unsigned CAPACITY = 128,
  parameter int unsigned IW       = 7,
  parameter int unsigned CW       = 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            accept_i,
  input  wire logic [2:0]                      cmd_i,
  input  wire logic [cdq_pkg::DATA_W-1:0]      value_i,
  // prefetched ring[head + 1] and ring[tail - 1]
  input  wire logic [cdq_pkg::DATA_W-1:0]      next_front_i,
  input  wire logic [cdq_pkg::DATA_W-1:0]      prev_back_i,
  output logic                                 we_o,
  output logic [IW-1:0]                        waddr_o,
  output logic [cdq_pkg::DATA_W-1:0]           wdata_o,
  output logic [IW-1:0]                        raddr_a_o,
  output logic [IW-1:0]                        raddr_b_o,
  output cdq_pkg::cdq_status_e                 status_o,
  output cdq_pkg::cdq_result_t                 result_o
);

  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

  logic [IW-1:0]                head_q, head_d;
  logic [IW-1:0]                tail_q, tail_d;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic [cdq_pkg::DATA_W-1:0]   front_q, front_d;
  logic [cdq_pkg::DATA_W-1:0]   back_q, back_d;
  logic                         empty_now;
  logic                         full_now;
  logic                         empty_nxt;
  logic [CW+7:0]                cnt_ext;
  cdq_pkg::cdq_cmd_e            cmd;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] i);
    return (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  assign cmd       = cdq_pkg::cdq_cmd_e'(cmd_i);
  assign empty_now = (cnt_q == '0);
  assign full_now  = (cnt_q == FULL_CNT);

  // Command decode and next state
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    front_d  = front_q;
    back_d   = back_q;
    we_o     = 1'b0;
    waddr_o  = head_q;
    wdata_o  = value_i;
    status_o = cdq_pkg::ST_OK;
    if (accept_i) begin
      unique case (cmd) inside
        cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_BACK: begin
          if (full_now) begin
            status_o = cdq_pkg::ST_OVERFLOW;
          end else begin
            we_o  = 1'b1;
            cnt_d = cnt_q + 1'b1;
            if (empty_now) begin
              // first element always lands in entry zero
              head_d  = '0;
              tail_d  = '0;
              waddr_o = '0;
              front_d = value_i;
              back_d  = value_i;
            end else if (cmd == cdq_pkg::CMD_PUSH_FRONT) begin
              head_d  = idx_dec(head_q);
              waddr_o = head_d;
              front_d = value_i;
            end else begin
              tail_d  = idx_inc(tail_q);
              waddr_o = tail_d;
              back_d  = value_i;
            end
          end
        end
        cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_BACK: begin
          if (empty_now) begin
            status_o = cdq_pkg::ST_UNDERFLOW;
          end else begin
            cnt_d = cnt_q - 1'b1;
            if (cnt_q == CW'(1)) begin
              // last element gone: indices return home
              head_d = '0;
              tail_d = '0;
            end else if (cmd == cdq_pkg::CMD_POP_FRONT) begin
              head_d  = idx_inc(head_q);
              front_d = next_front_i;
            end else begin
              tail_d = idx_dec(tail_q);
              back_d = prev_back_i;
            end
          end
        end
        default: begin
          // query and unused codes leave state alone
        end
      endcase
    end
  end

  // Prefetch neighbours of the ends for the following cycle
  assign raddr_a_o = idx_inc(head_d);
  assign raddr_b_o = idx_dec(tail_d);

  // Post-operation result
  assign empty_nxt = (cnt_d == '0);
  assign cnt_ext   = {8'b0, cnt_d};

  always_comb begin
    result_o.front_value = empty_nxt ? cdq_pkg::EMPTY_VALUE : front_d;
    result_o.back_value  = empty_nxt ? cdq_pkg::EMPTY_VALUE : back_d;
    result_o.count       = cnt_ext[7:0];
    result_o.is_empty    = empty_nxt;
    result_o.is_full     = (cnt_d == FULL_CNT);
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  // Cached end values, meaningful only while elements are stored
  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    back_q  <= back_d;
  end

endmodule : cdq_ctrl
`default_nettype wire

// ===== rtl/circular_deque_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// circular_deque_core
// Double-ended queue of signed 32-bit values in a ring store of CAPACITY
// entries; one result beat for every command beat.
// ----------------------------------------------------------------------------
//  Channel  Dir  tuser            tdata
//  s_axis   in   cmd[2:0]         value[31:0]
//  m_axis   out  status[1:0]      front, back, count, is_empty, is_full
//
//  One command per cycle unless stalled; result the cycle after acceptance.
//  The rate is set by the single write port of the ring store together
//  with the two registered prefetch reads of the entries next to the ends.
//  Reset clears indices, count and the output valid; the store needs no
//  clearing, as only entries holding elements are ever reported.
//  A stalled output holds its beat, and s_axis_tready drops with it.
// ----------------------------------------------------------------------------
module circular_deque_core #(
  parameter int unsigned CAPACITY = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // value[31:0]
  input  wire logic [2:0]  s_axis_tuser,   // cmd[2:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // front_value[31:0], back_value[63:32], count[71:64], is_empty[72],
  // is_full[73], zero[79:74]
  output logic [79:0]      m_axis_tdata,
  output logic [1:0]       m_axis_tuser    // status[1:0]
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PAD_W =
      cdq_pkg::OUT_DATA_W - $bits(cdq_pkg::cdq_result_t);

  logic                          accept;
  logic                          we;
  logic [IW-1:0]                 waddr;
  logic [cdq_pkg::DATA_W-1:0]    wdata;
  logic [IW-1:0]                 raddr_a;
  logic [IW-1:0]                 raddr_b;
  logic [cdq_pkg::DATA_W-1:0]    rdata_a;
  logic [cdq_pkg::DATA_W-1:0]    rdata_b;
  cdq_pkg::cdq_status_e          status;
  cdq_pkg::cdq_result_t          result;
  logic                          m_valid_q;
  cdq_pkg::cdq_result_t          m_result_q;
  cdq_pkg::cdq_status_e          m_status_q;

  // Input beat taken whenever the output register is free or draining
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  cdq_ctrl #(
    .CAPACITY (CAPACITY),
    .IW       (IW),
    .CW       (CW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .cmd_i        (s_axis_tuser),
    .value_i      (s_axis_tdata),
    .next_front_i (rdata_a),
    .prev_back_i  (rdata_b),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .raddr_a_o    (raddr_a),
    .raddr_b_o    (raddr_b),
    .status_o     (status),
    .result_o     (result)
  );

  cdq_ring_ram #(
    .DEPTH (CAPACITY),
    .AW    (IW),
    .DW    (cdq_pkg::DATA_W)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (accept) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_result_q <= result;
      m_status_q <= status;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, m_result_q};
  assign m_axis_tuser  = m_status_q;

endmodule : circular_deque_core
`default_nettype wire
